@@ hw/rtl/plma_pkg.sv @@
// Shared types and constants for the per-label moment accumulator.
package plma_pkg;

  localparam int unsigned LabelW = 6;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 21;
  localparam int unsigned SumW   = 53;
  localparam int unsigned QuotW  = 32;
  localparam int unsigned NumSums = 9;
  localparam int unsigned SumSelW = 4;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StMul,
    StAcc,
    StLoad,
    StDiv,
    StEmit
  } state_e;

endpackage

@@ hw/rtl/per_label_moment_accumulator.sv @@
// Top level of the per-label moment accumulator.
// Each pixel word is handled in steps: the accept step, then one multiply step and one accumulate
// step for each of the nine sums. One shared 17x17 multiplier and one shared adder update the
// sums of the pixel's plane one after another, through a single-port sum memory.
// After reset, and after each frame's results, a clearing pass zeroes all 9*MAX_PLANES words of
// the memory while no pixel is taken. On frame_end each active plane is divided and then sent as
// one result, held through any output stall: one shared restoring divider makes one quotient bit
// a cycle for each of the nine means.
module per_label_moment_accumulator #(
  parameter int unsigned MAX_PLANES       = 32,
  parameter int unsigned MAX_FRAME_PIXELS = 1048576
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_data_i,        // plane_count[5:0]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,      // plane_label[5:0], coord_x, coord_y, coord_z
  input  logic         s_axis_tlast,      // frame_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [263:0] m_axis_tdata,      // plane_index, pixel_total, mean_x..z, mean_xx..zz,
                                          // mean_xy, mean_yz, mean_xz
  output logic         m_axis_tlast       // final_plane
);
  import plma_pkg::*;

  localparam int unsigned PW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int unsigned Depth = NumSums * MAX_PLANES;
  localparam int unsigned AW    = $clog2(Depth + 1);
  localparam int unsigned DivW  = SumW + 1;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  state_e state_q, state_d;
  logic [LabelW-1:0] plane_count_q;
  logic [CountW-1:0] counts_q [MAX_PLANES];
  logic signed [SumW-1:0] sum_mem [Depth];
  logic signed [SumW-1:0] rd_q;
  logic [AW-1:0] addr_q;
  logic [SumSelW-1:0] sel_q;
  logic [PW-1:0] plane_q;
  logic signed [CoordW-1:0] x_q, y_q, z_q;
  logic last_q, take_q;
  logic signed [33:0] prod_q;
  logic [SumW-1:0] num_q;
  logic [SumW:0] rem_q;
  logic [SumW-1:0] quot_q;
  logic neg_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [QuotW-1:0] means_q [NumSums];
  logic [6:0] act;
  logic [PW-1:0] lab;

  assign act = (7'(plane_count_q) > 7'(MAX_PLANES)) ? 7'(MAX_PLANES) : 7'(plane_count_q);
  assign lab = s_axis_tdata[PW-1:0];
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == StIdle);

  logic [AW-1:0] base;
  assign base = AW'(plane_q) * AW'(NumSums);

  logic signed [CoordW:0] ma, mb;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (sel_q)
      4'd0: begin ma = x_q; mb = 17'sd1; end
      4'd1: begin ma = y_q; mb = 17'sd1; end
      4'd2: begin ma = z_q; mb = 17'sd1; end
      4'd3: begin ma = x_q; mb = x_q; end
      4'd4: begin ma = y_q; mb = y_q; end
      4'd5: begin ma = z_q; mb = z_q; end
      4'd6: begin ma = x_q; mb = y_q; end
      4'd7: begin ma = y_q; mb = z_q; end
      4'd8: begin ma = x_q; mb = z_q; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic [CountW-1:0] cnt;
  assign cnt = counts_q[plane_q];
  logic [SumW:0] trial;
  assign trial = {rem_q[SumW-1:0], num_q[SumW-1]} - {{(SumW+1-CountW){1'b0}}, cnt};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (addr_q == AW'(Depth - 1)) state_d = StIdle;
      StIdle:  if (s_axis_tvalid) state_d = StMul;
      StMul:   state_d = StAcc;
      StAcc: begin
        if (sel_q != SumSelW'(NumSums - 1)) state_d = StMul;
        else if (last_q) state_d = (act == 0) ? StClear : StLoad;
        else state_d = StIdle;
      end
      StLoad:  state_d = StDiv;
      StDiv: begin
        if (dcnt_q == DivCntW'(SumW)) begin
          state_d = (sel_q == SumSelW'(NumSums - 1)) ? StEmit : StLoad;
        end
      end
      StEmit: if (m_axis_tready) begin
        state_d = (7'(plane_q) + 7'd1 == act) ? StClear : StLoad;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      plane_count_q <= '0;
      addr_q <= '0;
      sel_q <= '0;
      plane_q <= '0;
      for (int i = 0; i < MAX_PLANES; i++) counts_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) plane_count_q <= cfg_data_i[LabelW-1:0];
      unique case (state_q)
        StClear: begin
          addr_q <= (addr_q == AW'(Depth - 1)) ? '0 : addr_q + 1'b1;
          plane_q <= '0;
          sel_q <= '0;
          if (addr_q == '0) for (int i = 0; i < MAX_PLANES; i++) counts_q[i] <= '0;
        end
        StIdle: if (s_axis_tvalid) begin
          plane_q <= lab;
          sel_q <= '0;
          if (7'(s_axis_tdata[LabelW-1:0]) < act &&
              counts_q[lab] < CountW'(MAX_FRAME_PIXELS)) begin
            counts_q[lab] <= counts_q[lab] + 1'b1;
          end
        end
        StAcc: begin
          if (sel_q != SumSelW'(NumSums - 1)) sel_q <= sel_q + 1'b1;
          else begin
            sel_q <= '0;
            plane_q <= '0;
            addr_q <= '0;
          end
        end
        StDiv: if (dcnt_q == DivCntW'(SumW)) begin
          if (sel_q != SumSelW'(NumSums - 1)) sel_q <= sel_q + 1'b1;
        end
        StEmit: if (m_axis_tready) begin
          sel_q <= '0;
          plane_q <= plane_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) begin
      x_q <= s_axis_tdata[21:6];
      y_q <= s_axis_tdata[37:22];
      z_q <= s_axis_tdata[53:38];
      last_q <= s_axis_tlast;
      take_q <= 7'(s_axis_tdata[LabelW-1:0]) < act &&
                counts_q[lab] < CountW'(MAX_FRAME_PIXELS);
    end
    if (state_q == StClear) sum_mem[addr_q[AW-1:0]] <= '0;
    if (state_q == StMul || state_q == StLoad) rd_q <= sum_mem[base + AW'(sel_q)];
    if (state_q == StMul) prod_q <= 34'(ma) * 34'(mb);
    if (state_q == StAcc && take_q) sum_mem[base + AW'(sel_q)] <= rd_q + SumW'(prod_q);
    if (state_q == StLoad) dcnt_q <= '0;
    if (state_q == StDiv) begin
      if (dcnt_q == '0) begin
        neg_q <= rd_q[SumW-1];
        num_q <= rd_q[SumW-1] ? SumW'(-rd_q) : SumW'(rd_q);
        rem_q <= '0;
        quot_q <= '0;
        dcnt_q <= dcnt_q + 1'b1;
      end else if (dcnt_q != DivCntW'(SumW)) begin
        if (!trial[SumW]) rem_q <= trial;
        else rem_q <= {rem_q[SumW-1:0], num_q[SumW-1]};
        quot_q <= {quot_q[SumW-2:0], ~trial[SumW]};
        num_q <= {num_q[SumW-2:0], 1'b0};
        dcnt_q <= dcnt_q + 1'b1;
      end
    end
    if (state_q == StDiv && dcnt_q == DivCntW'(SumW)) begin
      logic [SumW-1:0] qf;
      qf = {quot_q[SumW-2:0], ~trial[SumW]};
      if (cnt == '0) means_q[sel_q] <= '0;
      else means_q[sel_q] <= neg_q ? QuotW'(-qf) : QuotW'(qf);
    end
  end

  logic [4:0] pidx;
  assign pidx = 5'(plane_q);
  assign m_axis_tvalid = (state_q == StEmit);
  assign m_axis_tlast = (7'(plane_q) + 7'd1 == act);
  assign m_axis_tdata = {1'b0, means_q[8], means_q[7], means_q[6],
                         means_q[5][30:0], means_q[4][30:0], means_q[3][30:0],
                         means_q[2][15:0], means_q[1][15:0], means_q[0][15:0],
                         cnt, pidx};

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while emitting");
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 7'(plane_q) < act) else $error("plane out of range");
endmodule
